[rtl/negacyclic_poly_mul_acc_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for negacyclic_poly_mul_acc
// Implication checks, sampled on the rising clock and off during reset.
// ----------------------------------------------------------------------------
`ifndef NEGACYCLIC_POLY_MUL_ACC_ASSERT_SVH
`define NEGACYCLIC_POLY_MUL_ACC_ASSERT_SVH

// Same-cycle implication
`define NMAC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nmac assertion failed");

// Next-cycle implication
`define NMAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nmac assertion failed");

`endif

[rtl/nmac_pkg.sv]
// ----------------------------------------------------------------------------
// nmac_pkg
// Shared types and constants of the negacyclic multiply-accumulate block.
// ----------------------------------------------------------------------------
package nmac_pkg;

   localparam int COEF_W         = 62;
   localparam int DEG_W          = 6;
   localparam int CSR_IDX_W      = 1;
   localparam int MAX_DEGREE_DEF = 32;
   localparam logic [DEG_W-1:0]  DEGREE_RESET  = DEG_W'(32);
   localparam logic [COEF_W-1:0] MODULUS_RESET = COEF_W'(2);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 1'b1;

   typedef struct packed {
      logic [COEF_W-1:0] coef_a;
      logic [COEF_W-1:0] coef_b;
      logic              last_coef;
      logic              last_term;
   } req_item_type;

   typedef struct packed {
      logic [COEF_W-1:0] result_coef;
      logic              result_last;
   } rsp_item_type;

   // Operand source of the serial modular unit
   typedef enum logic [2:0] {
      SRC_IN_A    = 3'd0,
      SRC_IN_B    = 3'd1,
      SRC_MEM_A   = 3'd2,
      SRC_MEM_B   = 3'd3,
      SRC_MEM_ACC = 3'd4,
      SRC_MUL     = 3'd5
   } src_type;

   typedef struct packed {
      logic    latch;
      logic    start;
      src_type src;
      logic    wr_a;
      logic    wr_b;
      logic    wr_acc;
      logic    upd_acc;
      logic    sub;
      logic    clr_op;
      logic    clr_acc;
      logic    out_load;
      logic    out_last;
   } cmd_type;

   typedef struct packed {
      logic unit_busy;
      logic last_coef;
      logic last_term;
      logic out_free;
   } status_type;

endpackage

[rtl/nmac_stream_if.sv]
// ----------------------------------------------------------------------------
// nmac_stream_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface nmac_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/nmac_datapath.sv]
// ----------------------------------------------------------------------------
// nmac_datapath
// Config registers, operand and accumulator stores, serial mod-q unit,
// accumulator update and the output register.
// ----------------------------------------------------------------------------
module nmac_datapath #(
   parameter int MAX_DEGREE = nmac_pkg::MAX_DEGREE_DEF,
   localparam int IW = $clog2(MAX_DEGREE),
   localparam int CW = $clog2(MAX_DEGREE + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [nmac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nmac_pkg::COEF_W-1:0]    csr_wdata,
   input  nmac_pkg::req_item_type         req_payload,
   input  nmac_pkg::cmd_type              cmd,
   input  logic [IW-1:0]                  idx_a,
   input  logic [IW-1:0]                  idx_b,
   input  logic [IW-1:0]                  idx_acc,
   output nmac_pkg::status_type           status,
   output logic [CW-1:0]                  d_eff,
   nmac_stream_if.source                  rsp_if
);
   import nmac_pkg::*;

   localparam int CNT_W = $clog2(2 * COEF_W + 1);

   logic [DEG_W-1:0]  degree_ff;
   logic [COEF_W-1:0] modulus_ff;
   logic [COEF_W-1:0] q;
   req_item_type      item_ff;

   logic [COEF_W-1:0]     a_mem_ff   [MAX_DEGREE];
   logic [COEF_W-1:0]     b_mem_ff   [MAX_DEGREE];
   logic [COEF_W-1:0]     acc_mem_ff [MAX_DEGREE];
   logic [MAX_DEGREE-1:0] a_vld_ff;
   logic [MAX_DEGREE-1:0] b_vld_ff;
   logic [MAX_DEGREE-1:0] acc_vld_ff;
   logic [COEF_W-1:0]     a_rd;
   logic [COEF_W-1:0]     b_rd;
   logic [COEF_W-1:0]     acc_rd;

   logic [COEF_W-1:0] r_ff, r_in;
   logic [COEF_W-1:0] x_ff;
   logic [COEF_W-1:0] add_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [COEF_W:0]   step_t;

   logic [COEF_W:0]   acc_sum;
   logic [COEF_W-1:0] acc_new;

   logic              rsp_vld_ff;
   rsp_item_type      rsp_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff  <= DEGREE_RESET;
         modulus_ff <= MODULUS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEGREE:  degree_ff  <= csr_wdata[DEG_W-1:0];
            CSR_MODULUS: modulus_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp degree and modulus to their working range
   always_comb begin
      if (degree_ff == '0) begin
         d_eff = CW'(1);
      end else if (degree_ff > DEG_W'(MAX_DEGREE)) begin
         d_eff = CW'(MAX_DEGREE);
      end else begin
         d_eff = CW'(degree_ff);
      end
      q = (modulus_ff < COEF_W'(2)) ? COEF_W'(2) : modulus_ff;
   end

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_ff <= req_payload;
      end
   end

   // Store reads; an entry without its valid bit reads as zero
   assign a_rd   = a_vld_ff[idx_a]     ? a_mem_ff[idx_a]     : '0;
   assign b_rd   = b_vld_ff[idx_b]     ? b_mem_ff[idx_b]     : '0;
   assign acc_rd = acc_vld_ff[idx_acc] ? acc_mem_ff[idx_acc] : '0;

   // Serial unit step: double on even counts, add on odd counts
   always_comb begin
      if (!cnt_ff[0]) begin
         step_t = {r_ff, 1'b0};
      end else begin
         step_t = {1'b0, r_ff} + {1'b0, (x_ff[COEF_W-1] ? add_ff : '0)};
      end
      if (step_t >= {1'b0, q}) begin
         step_t = step_t - {1'b0, q};
      end
      r_in = step_t[COEF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start) begin
         cnt_ff <= CNT_W'(2 * COEF_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         r_ff   <= '0;
         add_ff <= COEF_W'(1);
         case (cmd.src)
            SRC_IN_A:    x_ff <= item_ff.coef_a;
            SRC_IN_B:    x_ff <= item_ff.coef_b;
            SRC_MEM_A:   x_ff <= a_rd;
            SRC_MEM_B:   x_ff <= b_rd;
            SRC_MEM_ACC: x_ff <= acc_rd;
            SRC_MUL: begin
               x_ff   <= b_rd;
               add_ff <= a_rd;
            end
            default:     x_ff <= '0;
         endcase
      end else if (cnt_ff != '0) begin
         r_ff <= r_in;
         if (cnt_ff[0]) begin
            x_ff <= {x_ff[COEF_W-2:0], 1'b0};
         end
      end
   end

   // Accumulator add or subtract of the finished product
   always_comb begin
      if (!cmd.sub) begin
         acc_sum = {1'b0, acc_rd} + {1'b0, r_ff};
         if (acc_sum >= {1'b0, q}) begin
            acc_sum = acc_sum - {1'b0, q};
         end
      end else if (acc_rd >= r_ff) begin
         acc_sum = {1'b0, acc_rd - r_ff};
      end else begin
         acc_sum = {1'b0, acc_rd} + {1'b0, q - r_ff};
      end
      acc_new = acc_sum[COEF_W-1:0];
   end

   // Store writes
   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         a_mem_ff[idx_a] <= r_ff;
      end
      if (cmd.wr_b) begin
         b_mem_ff[idx_b] <= r_ff;
      end
      if (cmd.wr_acc) begin
         acc_mem_ff[idx_acc] <= r_ff;
      end else if (cmd.upd_acc) begin
         acc_mem_ff[idx_acc] <= acc_new;
      end
   end

   // Valid bits: set on write, drop the whole store on clear
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= '0;
         b_vld_ff   <= '0;
         acc_vld_ff <= '0;
      end else begin
         if (cmd.clr_op) begin
            a_vld_ff <= '0;
            b_vld_ff <= '0;
         end else begin
            if (cmd.wr_a) a_vld_ff[idx_a] <= 1'b1;
            if (cmd.wr_b) b_vld_ff[idx_b] <= 1'b1;
         end
         if (cmd.clr_acc) begin
            acc_vld_ff <= '0;
         end else if (cmd.wr_acc || cmd.upd_acc) begin
            acc_vld_ff[idx_acc] <= 1'b1;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.result_coef <= acc_rd;
         rsp_data_ff.result_last <= cmd.out_last;
      end
   end

   assign rsp_if.valid   = rsp_vld_ff;
   assign rsp_if.payload = rsp_data_ff;

   assign status.unit_busy = (cnt_ff != '0);
   assign status.last_coef = item_ff.last_coef;
   assign status.last_term = item_ff.last_term;
   assign status.out_free  = !rsp_vld_ff || rsp_if.ready;

endmodule

[rtl/nmac_ctrl.sv]
// ----------------------------------------------------------------------------
// nmac_ctrl
// Sequencer: item load, re-reduction pass, product loop over (i, j) and
// result emission.
// ----------------------------------------------------------------------------
module nmac_ctrl #(
   parameter int MAX_DEGREE = nmac_pkg::MAX_DEGREE_DEF,
   localparam int IW = $clog2(MAX_DEGREE),
   localparam int CW = $clog2(MAX_DEGREE + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nmac_pkg::status_type status,
   input  logic [CW-1:0]        d_eff,
   output nmac_pkg::cmd_type    cmd,
   output logic [IW-1:0]        idx_a,
   output logic [IW-1:0]        idx_b,
   output logic [IW-1:0]        idx_acc
);
   import nmac_pkg::*;

   localparam int SW = IW + 1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_RED_A = 8'b0000_0010,
      ST_RED_B = 8'b0000_0100,
      ST_POST  = 8'b0000_1000,
      ST_PRE   = 8'b0001_0000,
      ST_MUL   = 8'b0010_0000,
      ST_UPD   = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic          started_ff, started_in;
   logic [CW-1:0] coef_idx_ff, coef_idx_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic [IW-1:0] kp_ff, kp_in;
   logic [1:0]    sel_ff, sel_in;

   logic [SW-1:0] sum_ij;
   logic          wrap;
   logic [SW-1:0] k_sum;
   logic          kp_last;
   logic          i_last;
   logic          j_last;
   logic          done;

   // Product index with negacyclic wrap
   assign sum_ij  = SW'(i_ff) + SW'(j_ff);
   assign wrap    = (sum_ij >= SW'(d_eff));
   assign k_sum   = wrap ? (sum_ij - SW'(d_eff)) : sum_ij;
   assign kp_last = (CW'(kp_ff) == d_eff - CW'(1));
   assign i_last  = (CW'(i_ff) == d_eff - CW'(1));
   assign j_last  = (CW'(j_ff) == d_eff - CW'(1));
   assign done    = started_ff && !status.unit_busy;

   // Store addresses by phase
   always_comb begin
      idx_a   = i_ff;
      idx_b   = j_ff;
      idx_acc = k_sum[IW-1:0];
      if (state_ff == ST_RED_A || state_ff == ST_RED_B) begin
         idx_a = coef_idx_ff[IW-1:0];
         idx_b = coef_idx_ff[IW-1:0];
      end else if (state_ff == ST_PRE || state_ff == ST_EMIT) begin
         idx_a   = kp_ff;
         idx_b   = kp_ff;
         idx_acc = kp_ff;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      started_in  = started_ff;
      coef_idx_in = coef_idx_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      kp_in       = kp_ff;
      sel_in      = sel_ff;
      cmd         = '0;
      cmd.src     = SRC_IN_A;
      req_ready   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = (coef_idx_ff < d_eff) ? ST_RED_A : ST_POST;
            end
         end
         ST_RED_A: begin
            cmd.src = SRC_IN_A;
            if (!started_ff) begin
               cmd.start  = 1'b1;
               started_in = 1'b1;
            end else if (done) begin
               cmd.wr_a   = 1'b1;
               started_in = 1'b0;
               state_in   = ST_RED_B;
            end
         end
         ST_RED_B: begin
            cmd.src = SRC_IN_B;
            if (!started_ff) begin
               cmd.start  = 1'b1;
               started_in = 1'b1;
            end else if (done) begin
               cmd.wr_b   = 1'b1;
               started_in = 1'b0;
               state_in   = ST_POST;
            end
         end
         ST_POST: begin
            if (coef_idx_ff != CW'(MAX_DEGREE)) begin
               coef_idx_in = coef_idx_ff + CW'(1);
            end
            if (status.last_coef) begin
               kp_in    = '0;
               sel_in   = '0;
               state_in = ST_PRE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         // Re-reduce A, B and the accumulator under the current modulus
         ST_PRE: begin
            case (sel_ff)
               2'd0:    cmd.src = SRC_MEM_A;
               2'd1:    cmd.src = SRC_MEM_B;
               default: cmd.src = SRC_MEM_ACC;
            endcase
            if (!started_ff) begin
               cmd.start  = 1'b1;
               started_in = 1'b1;
            end else if (done) begin
               started_in = 1'b0;
               case (sel_ff)
                  2'd0:    cmd.wr_a   = 1'b1;
                  2'd1:    cmd.wr_b   = 1'b1;
                  default: cmd.wr_acc = 1'b1;
               endcase
               if (sel_ff == 2'd2) begin
                  sel_in = '0;
                  if (kp_last) begin
                     i_in     = '0;
                     j_in     = '0;
                     state_in = ST_MUL;
                  end else begin
                     kp_in = kp_ff + IW'(1);
                  end
               end else begin
                  sel_in = sel_ff + 2'd1;
               end
            end
         end
         ST_MUL: begin
            cmd.src = SRC_MUL;
            if (!started_ff) begin
               cmd.start  = 1'b1;
               started_in = 1'b1;
            end else if (done) begin
               started_in = 1'b0;
               state_in   = ST_UPD;
            end
         end
         // Fold the product into the accumulator and advance (i, j)
         ST_UPD: begin
            cmd.upd_acc = 1'b1;
            cmd.sub     = wrap;
            state_in    = ST_MUL;
            if (j_last) begin
               j_in = '0;
               if (i_last) begin
                  cmd.clr_op  = 1'b1;
                  coef_idx_in = '0;
                  kp_in       = '0;
                  state_in    = status.last_term ? ST_EMIT : ST_IDLE;
               end else begin
                  i_in = i_ff + IW'(1);
               end
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = kp_last;
               if (kp_last) begin
                  cmd.clr_acc = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  kp_in = kp_ff + IW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         started_ff  <= 1'b0;
         coef_idx_ff <= '0;
         i_ff        <= '0;
         j_ff        <= '0;
         kp_ff       <= '0;
         sel_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         started_ff  <= started_in;
         coef_idx_ff <= coef_idx_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         kp_ff       <= kp_in;
         sel_ff      <= sel_in;
      end
   end

endmodule

[rtl/negacyclic_poly_mul_acc.sv]
// ----------------------------------------------------------------------------
// negacyclic_poly_mul_acc
// Schoolbook multiply-accumulate in Z_q[X]/(X^d+1) for one matrix row.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one coefficient of each operand per item, index order,
//   with last_coef on the final pair item and last_term on the row end.
//   rsp_if returns the d reduced accumulator coefficients, result_last on
//   the final one. csr_* writes degree (index 0) and modulus (index 1).
// Flow (all modular work runs through one bit-serial unit, with a start
//   and a write-back around each run):
//   - item with index < d: one run on A and one on B; otherwise none.
//   - pair end adds 3*d runs of re-reduction and d*d runs of products.
//   - row end then puts out one result per cycle while rsp_if.ready holds.
// The output register lets the next item in while the last result waits;
//   a stalled receiver holds the block in emission until it takes items.
// Reset clears the registers to degree 32 and modulus 2 and empties the
//   operand and accumulator stores through their valid bits.
// ----------------------------------------------------------------------------
module negacyclic_poly_mul_acc #(
   parameter int MAX_DEGREE = nmac_pkg::MAX_DEGREE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [nmac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nmac_pkg::COEF_W-1:0]    csr_wdata,
   nmac_stream_if.sink                    req_if,
   nmac_stream_if.source                  rsp_if
);
   import nmac_pkg::*;

   localparam int IW = $clog2(MAX_DEGREE);
   localparam int CW = $clog2(MAX_DEGREE + 1);

   cmd_type       cmd;
   status_type    status;
   logic [CW-1:0] d_eff;
   logic [IW-1:0] idx_a;
   logic [IW-1:0] idx_b;
   logic [IW-1:0] idx_acc;
   logic          ctl_req_ready;

   nmac_ctrl #(
      .MAX_DEGREE(MAX_DEGREE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ctl_req_ready),
      .status    (status),
      .d_eff     (d_eff),
      .cmd       (cmd),
      .idx_a     (idx_a),
      .idx_b     (idx_b),
      .idx_acc   (idx_acc)
   );

   nmac_datapath #(
      .MAX_DEGREE(MAX_DEGREE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_if.payload),
      .cmd         (cmd),
      .idx_a       (idx_a),
      .idx_b       (idx_b),
      .idx_acc     (idx_acc),
      .status      (status),
      .d_eff       (d_eff),
      .rsp_if      (rsp_if)
   );

   assign req_if.ready = ctl_req_ready;

`include "negacyclic_poly_mul_acc_assert.svh"

   // The serial unit never runs while items are taken
   `NMAC_ASSERT_IMPLY(a_busy_not_ready, clock, reset, status.unit_busy, !req_if.ready)
   // Emission only outside the idle state
   `NMAC_ASSERT_IMPLY(a_out_not_ready, clock, reset, cmd.out_load, !req_if.ready)
   // The accumulator is dropped only with the final result
   `NMAC_ASSERT_IMPLY(a_clr_with_last, clock, reset, cmd.clr_acc, cmd.out_load && cmd.out_last)
   // A final result loaded shows up as a valid last item
   `NMAC_ASSERT_NEXT(a_last_shown, clock, reset, cmd.out_load && cmd.out_last, rsp_if.valid && rsp_if.payload.result_last)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the negacyclic multiply-accumulate block. Test
// tasks stream coefficient pairs under several degree and modulus settings,
// while a predictor in the bench computes the ring products mod q. Each
// result item is checked against the oldest predicted coefficient.
// ----------------------------------------------------------------------------
module tb_top;
   import nmac_pkg::*;

   localparam int MAXD       = MAX_DEGREE_DEF;
   localparam int IDLE_LIMIT = 600000;
   localparam logic [COEF_W-1:0] Q_MAX = {COEF_W{1'b1}};

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0]    csr_wdata;

   nmac_stream_if #(.payload_type(req_item_type)) req_ch ();
   nmac_stream_if #(.payload_type(rsp_item_type)) rsp_ch ();

   negacyclic_poly_mul_acc dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch.sink),
      .rsp_if    (rsp_ch.source)
   );

   // Ring state mirrored by the bench
   logic [DEG_W-1:0]  ring_degree;
   logic [COEF_W-1:0] ring_modulus;
   logic [COEF_W-1:0] a_coefs [MAXD];
   logic [COEF_W-1:0] b_coefs [MAXD];
   logic [COEF_W-1:0] row_sum [MAXD];
   int                load_index;

   rsp_item_type coef_queue [$];
   int           error_count;
   bit           quiet;
   int           hold_request;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int ring_d();
      if (ring_degree == 0) return 1;
      if (ring_degree > MAXD) return MAXD;
      return int'(ring_degree);
   endfunction

   function automatic logic [COEF_W-1:0] ring_q();
      return (ring_modulus < 2) ? COEF_W'(2) : ring_modulus;
   endfunction

   function automatic logic [COEF_W-1:0] mul_mod(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                                                 logic [COEF_W-1:0] q);
      logic [127:0] p;
      p = (128'(a) % 128'(q)) * (128'(b) % 128'(q));
      return COEF_W'(p % 128'(q));
   endfunction

   function automatic void clear_operands();
      for (int i = 0; i < MAXD; i++) begin
         a_coefs[i] = '0;
         b_coefs[i] = '0;
      end
      load_index = 0;
   endfunction

   // Load one coefficient pair; on a pair end fold the product into the row
   function automatic void predict_product(req_item_type it);
      int d;
      int k;
      logic [COEF_W-1:0] q;
      logic [COEF_W-1:0] p;
      logic [63:0] s;
      d = ring_d();
      q = ring_q();
      if (load_index < d) begin
         a_coefs[load_index] = it.coef_a % q;
         b_coefs[load_index] = it.coef_b % q;
      end
      if (load_index < MAXD) load_index++;
      if (!it.last_coef) return;
      for (int i = 0; i < d; i++) begin
         for (int j = 0; j < d; j++) begin
            p = mul_mod(a_coefs[i], b_coefs[j], q);
            k = i + j;
            // wrapped terms subtract since X^d = -1
            if (k < d) begin
               s = 64'(row_sum[k] % q) + 64'(p);
               row_sum[k] = COEF_W'(s % 64'(q));
            end else begin
               s = 64'(row_sum[k-d] % q) + 64'(q) - 64'(p);
               row_sum[k-d] = COEF_W'(s % 64'(q));
            end
         end
      end
      clear_operands();
      if (!it.last_term) return;
      for (int i = 0; i < d; i++) begin
         coef_queue.push_back('{result_coef: row_sum[i] % q, result_last: (i == d - 1)});
      end
      // drop the whole row, entries past the degree too
      for (int i = 0; i < MAXD; i++) row_sum[i] = '0;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // Receiver, result check and watchdog
   always @(posedge clock) begin
      static int hold_left = 0;
      static int rsp_gap = 0;
      static int idle_cycles = 0;
      rsp_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (coef_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected item coef=%h", rsp_ch.payload.result_coef));
            end else begin
               want = coef_queue.pop_front();
               if (rsp_ch.payload.result_coef !== want.result_coef)
                  report_mismatch($sformatf("result_coef %h, want %h",
                                            rsp_ch.payload.result_coef, want.result_coef));
               if (rsp_ch.payload.result_last !== want.result_last)
                  report_mismatch($sformatf("result_last %b, want %b",
                                            rsp_ch.payload.result_last, want.result_last));
            end
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet) begin
            rsp_ch.ready <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            rsp_gap = pick_gap();
         end
      end
   end

   // Offer one item and hold it until accepted
   task automatic send_item(input req_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= it;
      do @(posedge clock); while (!req_ch.ready);
      predict_product(it);
   endtask

   // Wait for all results, then let the block settle before a register write
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (coef_queue.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_DEGREE) ring_degree = data[DEG_W-1:0];
      else ring_modulus = data;
   endtask

   function automatic logic [COEF_W-1:0] rand62();
      return COEF_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [COEF_W-1:0] rand_coef();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return Q_MAX;
      if (r == 2) return ring_q() - 1;
      return rand62();
   endfunction

   // Stream one pair of n items; last_term on earlier items is noise
   task automatic send_pair(input int n, input bit row_end);
      req_item_type it;
      for (int k = 0; k < n; k++) begin
         it.coef_a    = rand_coef();
         it.coef_b    = rand_coef();
         it.last_coef = (k == n - 1);
         it.last_term = (k == n - 1) ? row_end : 1'($urandom_range(0, 1));
         send_item(it);
      end
   endtask

   task automatic send_fixed(input logic [COEF_W-1:0] v, input int n, input bit row_end);
      for (int k = 0; k < n; k++)
         send_item('{coef_a: v, coef_b: v, last_coef: (k == n - 1),
                     last_term: (k == n - 1) && row_end});
   endtask

   function automatic logic [COEF_W-1:0] rand_modulus();
      case ($urandom_range(0, 4))
         0: return COEF_W'(2);
         1: return Q_MAX;
         2: return rand62();
         3: return COEF_W'($urandom_range(2, 1000));
         default: return COEF_W'(1) << $urandom_range(1, 61);
      endcase
   endfunction

   // Full ring at reset values, with items past the degree
   task automatic test_reset_defaults();
      send_pair(34, 1'b1);
      wait_drained();
   endtask

   // Degree zero and moduli below two
   task automatic test_small_ring();
      csr_write(CSR_DEGREE, COEF_W'({rand62() >> DEG_W, 6'd0}));
      csr_write(CSR_MODULUS, '0);
      send_pair(1, 1'b1);
      send_pair(3, 1'b1);
      wait_drained();
      csr_write(CSR_MODULUS, COEF_W'(1));
      send_pair(2, 1'b0);
      send_pair(1, 1'b1);
      wait_drained();
   endtask

   // Field extremes at the largest modulus, short pairs, multi-pair row
   task automatic test_extremes();
      csr_write(CSR_DEGREE, COEF_W'(4));
      csr_write(CSR_MODULUS, Q_MAX);
      send_fixed(Q_MAX, 4, 1'b1);
      send_fixed(Q_MAX - 1, 4, 1'b0);
      send_fixed('0, 4, 1'b0);
      send_pair(2, 1'b0);
      send_pair(4, 1'b1);
      wait_drained();
   endtask

   // Index counter saturation on a long pair
   task automatic test_saturation();
      csr_write(CSR_DEGREE, COEF_W'(2));
      csr_write(CSR_MODULUS, rand62());
      send_pair(40, 1'b1);
      wait_drained();
   endtask

   // Degree above the maximum, pair ends early
   task automatic test_degree_clamp();
      csr_write(CSR_DEGREE, COEF_W'(63));
      csr_write(CSR_MODULUS, Q_MAX);
      send_pair(5, 1'b1);
      wait_drained();
   endtask

   // Receiver holds off while rows keep coming
   task automatic test_backpressure();
      csr_write(CSR_DEGREE, COEF_W'(2));
      csr_write(CSR_MODULUS, rand_modulus());
      quiet = 1'b1;
      hold_request = 6000;
      repeat (4) send_pair(2, 1'b1);
      quiet = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_rows();
      int d;
      int sent;
      int n;
      int r;
      for (int phase = 0; phase < 6; phase++) begin
         r = $urandom_range(0, 99);
         d = (r < 45) ? $urandom_range(1, 3) : (r < 88) ? $urandom_range(4, 5) : 8;
         csr_write(CSR_DEGREE, COEF_W'({rand62() >> DEG_W, 6'(d)}));
         csr_write(CSR_MODULUS, rand_modulus());
         quiet = (phase % 4 == 3);
         sent = 0;
         while (sent < 14) begin
            n = ($urandom_range(0, 9) < 7) ? d : $urandom_range(1, d + 2);
            send_pair(n, $urandom_range(0, 2) == 0);
            sent += n;
         end
         send_pair(d, 1'b1);
         quiet = 1'b0;
         wait_drained();
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_DEGREE;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      error_count    = 0;
      quiet          = 1'b0;
      hold_request   = 0;
      ring_degree    = DEGREE_RESET;
      ring_modulus   = MODULUS_RESET;
      clear_operands();
      for (int i = 0; i < MAXD; i++) row_sum[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_small_ring();
      test_extremes();
      test_saturation();
      test_degree_clamp();
      test_backpressure();
      test_random_rows();

      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

[negacyclic_poly_mul_acc.f]
+incdir+rtl
rtl/nmac_pkg.sv
rtl/nmac_stream_if.sv
rtl/nmac_datapath.sv
rtl/nmac_ctrl.sv
rtl/negacyclic_poly_mul_acc.sv
tb/tb_top.sv
